FILE: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, header layout and controller/datapath interface types
// for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int ALIGN_BYTES = 8;
  localparam int HDR_BYTES   = 8;
  localparam int SLOTS       = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);
  localparam int POS_W       = $clog2(HEAP_BYTES) + 2;

  localparam int REQ_W  = 13;
  localparam int NEED_W = REQ_W + 1;
  localparam int OFF_W  = 12;
  localparam int SIZE_W = 12;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_NOSPACE = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_NULL    = 3'd4
  } stat_t;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_WALK,
    ST_ALLOC_SPLIT,
    ST_ALLOC_MARK,
    ST_FREE_FIND,
    ST_FREE_MARK,
    ST_COAL_START,
    ST_COAL_C,
    ST_COAL_N,
    ST_COAL_MERGE,
    ST_RESULT
  } fsm_t;

  typedef enum logic [1:0] {RD_NONE, RD_ZERO, RD_WALK, RD_MERGE} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_SPLIT, WR_CUR} wr_sel_t;
  typedef enum logic [1:0] {CUR_HOLD, CUR_TAKE, CUR_TRIM, CUR_GROW} cur_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_ADD, CNT_SUB} cnt_op_t;

  typedef struct packed {
    logic    load_req;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    wr_used;
    cur_op_t cur_op;
    cnt_op_t cnt_op;
    logic    res_load;
    stat_t   res_status;
    logic    res_grant;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_free;
    logic in_zero;
    logic in_null;
    logic in_badoff;
    logic fit;
    logic split;
    logic walk_end;
    logic match;
    logic past;
    logic hdr_used;
    logic merge;
    logic merge_end;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/ffa_dpath.sv
// ----------------------------------------------------------------------------
// ffa_dpath
// Header memory, chunk walk arithmetic, running totals and result registers.
// ----------------------------------------------------------------------------
module ffa_dpath import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              operation,
  input  logic [REQ_W-1:0]  request_size,
  input  logic [OFF_W-1:0]  block_offset,
  input  logic              null_pointer,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [STAT_W-1:0] status,
  output logic [OFF_W-1:0]  payload_offset,
  output logic [SIZE_W-1:0] granted_size,
  output logic [SIZE_W-1:0] live_bytes,
  output logic [CNT_W-1:0]  live_objects
);

  localparam logic [POS_W-1:0] HDR_P  = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] HEAP_P = POS_W'(HEAP_BYTES);

  logic [SIZE_W:0] mem [SLOTS];
  hdr_t            mem_q;
  logic            rd_dflt_q;
  logic            slot0_written;

  logic [NEED_W-1:0] need_q;
  logic [OFF_W-1:0]  boff_q;
  logic [POS_W-1:0]  rd_pos_q;
  logic [POS_W-1:0]  cur_pos_q;
  logic [SIZE_W-1:0] cur_size_q;
  logic              cur_used_q;
  logic [SIZE_W-1:0] bytes_q;
  logic [CNT_W-1:0]  count_q;

  stat_t             res_status_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [SIZE_W-1:0] res_size_q;

  logic              out_valid_q;
  stat_t             out_status_q;
  logic [OFF_W-1:0]  out_off_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [SIZE_W-1:0] out_bytes_q;
  logic [CNT_W-1:0]  out_count_q;

  logic [NEED_W-1:0] need;
  hdr_t              hdr;
  logic [POS_W-1:0]  walk_sum;
  logic [POS_W-1:0]  merge_sum;
  logic [POS_W-1:0]  hdr_end;
  logic [POS_W-1:0]  split_pos;
  logic [POS_W-1:0]  rd_addr;
  logic              rd_en;
  logic [POS_W-1:0]  wr_addr;
  hdr_t              wr_data;
  logic              wr_en;

  // Round the request up to the alignment unit.
  assign need = (NEED_W'(request_size) + NEED_W'(ALIGN_BYTES - 1))
                & ~NEED_W'(ALIGN_BYTES - 1);

  // Slot zero reads as one free chunk spanning the heap until first written.
  always_comb begin
    if (rd_dflt_q) begin
      hdr.used = 1'b0;
      hdr.size = SIZE_W'(HEAP_BYTES - HDR_BYTES);
    end else begin
      hdr = mem_q;
    end
  end

  assign walk_sum  = rd_pos_q + HDR_P + POS_W'(hdr.size);
  assign merge_sum = cur_pos_q + HDR_P + POS_W'(cur_size_q);
  assign hdr_end   = rd_pos_q + HDR_P;
  assign split_pos = cur_pos_q + HDR_P + POS_W'(need_q);

  always_comb begin
    stat.in_free   = operation;
    stat.in_zero   = (request_size == '0);
    stat.in_null   = null_pointer;
    stat.in_badoff = (POS_W'(block_offset) < HDR_P) || (POS_W'(block_offset) >= HEAP_P);
    stat.fit       = !hdr.used && ((NEED_W + 1)'(hdr.size) >= (NEED_W + 1)'(need_q));
    stat.split     = (NEED_W + 1)'(hdr.size) >=
                     ((NEED_W + 1)'(need_q) + (NEED_W + 1)'(HDR_BYTES + ALIGN_BYTES));
    stat.walk_end  = (walk_sum >= HEAP_P);
    stat.match     = (hdr_end == POS_W'(boff_q));
    stat.past      = (hdr_end > POS_W'(boff_q));
    stat.hdr_used  = hdr.used;
    stat.merge     = !cur_used_q && !hdr.used;
    stat.merge_end = (merge_sum >= HEAP_P);
    stat.out_free  = !out_valid_q || out_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_WALK:  rd_addr = walk_sum;
      RD_MERGE: rd_addr = merge_sum;
      default:  rd_addr = '0;
    endcase
    rd_en = (cmd.rd_sel != RD_NONE);
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_SPLIT: begin
        wr_addr      = split_pos;
        wr_data.used = 1'b0;
        wr_data.size = cur_size_q - SIZE_W'(need_q) - SIZE_W'(HDR_BYTES);
      end
      WR_CUR: begin
        wr_addr      = cur_pos_q;
        wr_data.used = cmd.wr_used;
        wr_data.size = cur_size_q;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
    wr_en = (cmd.wr_sel != WR_NONE);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ALIGN_SH +: SLOT_W]] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr[ALIGN_SH +: SLOT_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_written <= 1'b0;
      rd_dflt_q     <= 1'b0;
    end else begin
      if (wr_en && (wr_addr[ALIGN_SH +: SLOT_W] == '0)) begin
        slot0_written <= 1'b1;
      end
      if (rd_en) begin
        rd_dflt_q <= (rd_addr[ALIGN_SH +: SLOT_W] == '0) && !slot0_written;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      need_q <= need;
      boff_q <= block_offset;
    end
    if (rd_en) begin
      rd_pos_q <= rd_addr;
    end
    unique case (cmd.cur_op)
      CUR_TAKE: begin
        cur_pos_q  <= rd_pos_q;
        cur_size_q <= hdr.size;
        cur_used_q <= hdr.used;
      end
      CUR_TRIM: cur_size_q <= SIZE_W'(need_q);
      CUR_GROW: cur_size_q <= cur_size_q + SIZE_W'(HDR_BYTES) + hdr.size;
      default: ;
    endcase
    if (cmd.res_load) begin
      res_status_q <= cmd.res_status;
      res_off_q    <= cmd.res_grant ? OFF_W'(cur_pos_q + HDR_P) : '0;
      res_size_q   <= cmd.res_grant ? cur_size_q : '0;
    end
    if (cmd.out_load) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_size_q   <= res_size_q;
      out_bytes_q  <= bytes_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_ADD: begin
          bytes_q <= bytes_q + cur_size_q;
          count_q <= count_q + CNT_W'(1);
        end
        CNT_SUB: begin
          bytes_q <= bytes_q - cur_size_q;
          count_q <= count_q - CNT_W'(1);
        end
        default: ;
      endcase
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_q;
  assign status         = out_status_q;
  assign payload_offset = out_off_q;
  assign granted_size   = out_size_q;
  assign live_bytes     = out_bytes_q;
  assign live_objects   = out_count_q;

endmodule

FILE: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate search, split, free lookup and the coalescing pass.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  fsm_t state, state_next;
  logic accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!stat.in_free) begin
            state_next = stat.in_zero ? ST_RESULT : ST_ALLOC_WALK;
          end else if (stat.in_null || stat.in_badoff) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_FREE_FIND;
          end
        end
      end
      ST_ALLOC_WALK: begin
        if (stat.fit) begin
          state_next = stat.split ? ST_ALLOC_SPLIT : ST_ALLOC_MARK;
        end else if (stat.walk_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_ALLOC_SPLIT: state_next = ST_ALLOC_MARK;
      ST_ALLOC_MARK:  state_next = ST_RESULT;
      ST_FREE_FIND: begin
        if (stat.match) begin
          state_next = stat.hdr_used ? ST_FREE_MARK : ST_RESULT;
        end else if (stat.past || stat.walk_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_FREE_MARK:  state_next = ST_COAL_START;
      ST_COAL_START: state_next = ST_COAL_C;
      ST_COAL_C:     state_next = stat.walk_end ? ST_RESULT : ST_COAL_N;
      ST_COAL_N: begin
        if (stat.merge) begin
          state_next = ST_COAL_MERGE;
        end else if (stat.walk_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_COAL_MERGE: state_next = stat.merge_end ? ST_RESULT : ST_COAL_N;
      ST_RESULT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          if (!stat.in_free) begin
            if (stat.in_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_ZERO;
            end else begin
              cmd.rd_sel = RD_ZERO;
            end
          end else if (stat.in_null) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_NULL;
          end else if (stat.in_badoff) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_INVALID;
          end else begin
            cmd.rd_sel = RD_ZERO;
          end
        end
      end
      ST_ALLOC_WALK: begin
        if (stat.fit) begin
          cmd.cur_op = CUR_TAKE;
        end else if (stat.walk_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_NOSPACE;
        end else begin
          cmd.rd_sel = RD_WALK;
        end
      end
      ST_ALLOC_SPLIT: begin
        cmd.wr_sel = WR_SPLIT;
        cmd.cur_op = CUR_TRIM;
      end
      ST_ALLOC_MARK: begin
        cmd.wr_sel     = WR_CUR;
        cmd.wr_used    = 1'b1;
        cmd.cnt_op     = CNT_ADD;
        cmd.res_load   = 1'b1;
        cmd.res_status = STAT_DONE;
        cmd.res_grant  = 1'b1;
      end
      ST_FREE_FIND: begin
        if (stat.match) begin
          if (stat.hdr_used) begin
            cmd.cur_op = CUR_TAKE;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_INVALID;
          end
        end else if (stat.past || stat.walk_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_INVALID;
        end else begin
          cmd.rd_sel = RD_WALK;
        end
      end
      ST_FREE_MARK: begin
        cmd.wr_sel = WR_CUR;
        cmd.cnt_op = CNT_SUB;
      end
      ST_COAL_START: cmd.rd_sel = RD_ZERO;
      ST_COAL_C: begin
        cmd.cur_op = CUR_TAKE;
        if (stat.walk_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_DONE;
        end else begin
          cmd.rd_sel = RD_WALK;
        end
      end
      ST_COAL_N: begin
        // A free neighbor folds into the current chunk, which is then
        // checked again against its new successor.
        if (stat.merge) begin
          cmd.cur_op = CUR_GROW;
        end else begin
          cmd.cur_op = CUR_TAKE;
          if (stat.walk_end) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_DONE;
          end else begin
            cmd.rd_sel = RD_WALK;
          end
        end
      end
      ST_COAL_MERGE: begin
        cmd.wr_sel = WR_CUR;
        if (stat.merge_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_DONE;
        end else begin
          cmd.rd_sel = RD_MERGE;
        end
      end
      ST_RESULT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit list of chunk headers with coalescing.
// ----------------------------------------------------------------------------
// One request is in service at a time; a new request is taken while the
// previous result still waits at the output. Timing is set by the header
// memory, which is read at most once per cycle: an allocate visits each chunk
// header up to the first fit, then takes it, splits it when the rest can
// hold a header and payload, marks it and posts the result. A free walks the
// chunks up to the target; a used target is marked free, then a coalescing
// pass visits every chunk, with one more step per merge. The heap holds at
// most 256 chunks, since every chunk spans at least 16 bytes. Rejected
// requests (zero size, null or out-of-range pointer) go straight to posting
// the result. No memory clearing pass is needed after reset.
module first_fit_heap_allocator import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [REQ_W-1:0]  request_size,
  input  logic [OFF_W-1:0]  block_offset,
  input  logic              null_pointer,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [OFF_W-1:0]  payload_offset,
  output logic [SIZE_W-1:0] granted_size,
  output logic [SIZE_W-1:0] live_bytes,
  output logic [CNT_W-1:0]  live_objects
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffa_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .request_size   (request_size),
    .block_offset   (block_offset),
    .null_pointer   (null_pointer),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .payload_offset (payload_offset),
    .granted_size   (granted_size),
    .live_bytes     (live_bytes),
    .live_objects   (live_objects)
  );

endmodule
